>>> sv/pidaw_pkg.sv
// shared types, constants and helpers for the pid controller with anti-windup
package pidaw_pkg;

    // data format
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 31;
    localparam int LIMIT_W    = 31;
    localparam int WEIGHT_W   = 17;
    localparam int WEIGHT_FRAC = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT  = 3'd5;

    localparam logic [STEP_W-1:0]   STEP_RESET = 31'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    // serial multiplier: signed operands one bit wider than the data
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W - FRAC_W;

    // serial divider: difference of two samples, scaled up by the fraction
    localparam int DIFF_W    = DATA_W + 1;
    localparam int DIV_NUM_W = DIFF_W + FRAC_W;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_INT,
        ST_INT_SAT,
        ST_ISSUE_I,
        ST_MUL_I,
        ST_WAIT_DIV,
        ST_MUL_F1,
        ST_MUL_F2,
        ST_ISSUE_D,
        ST_MUL_D,
        ST_OUT
    } pid_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_ABS,
        DIV_RUN,
        DIV_FIN
    } div_state_t;

    // multiply request from the sequencer
    typedef struct packed {
        logic                    start;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    function automatic logic signed [MUL_W-1:0] sext_mul(input logic signed [DATA_W-1:0] x);
        return {x[DATA_W-1], x};
    endfunction

    // saturate a wide accumulator to the data range
    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[ACC_W-2:DATA_W-1];
        hi_zeros = ~|x[ACC_W-2:DATA_W-1];
        if (!x[ACC_W-1] && !hi_zeros)
            return DATA_MAX;
        else if (x[ACC_W-1] && !hi_ones)
            return DATA_MIN;
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

>>> sv/pidaw_smul.sv
// serial shift-add signed multiplier, one multiplier bit per cycle
module pidaw_smul (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  pidaw_pkg::mul_req_t                       req,
    output logic                                      done,
    output logic signed [pidaw_pkg::PROD_W-1:0]       prod
);

    localparam int MW = pidaw_pkg::MUL_W;
    localparam logic [5:0] LAST_STEP = 6'(MW - 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [MW-1:0] a_reg, a_next;
    logic [MW:0]   hi_reg, hi_next;
    logic [MW-1:0] lo_reg, lo_next;

    logic          last_step;
    logic [MW:0]   a_ext;
    logic [MW:0]   addend;
    logic [MW:0]   partial;

    assign last_step = (cnt_reg == LAST_STEP);
    assign a_ext     = {a_reg[MW-1], a_reg};
    // sign bit of the multiplier carries negative weight
    assign addend    = lo_reg[0] ? (last_step ? ((MW+1)'(0) - a_ext) : a_ext) : '0;
    assign partial   = hi_reg + addend;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            a_next   = req.a;
            hi_next  = '0;
            lo_next  = req.b;
        end
        else if (run_reg)
        begin
            hi_next  = {partial[MW], partial[MW:1]};
            lo_next  = {partial[0], lo_reg[MW-1:1]};
            cnt_next = cnt_reg + 6'd1;
            if (last_step)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg[MW-1:0], lo_reg};

endmodule

>>> sv/pidaw_sdiv.sv
// serial restoring divider for the derivative, one quotient bit per cycle
module pidaw_sdiv (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [pidaw_pkg::DIFF_W-1:0]       diff,
    input  logic        [pidaw_pkg::STEP_W-1:0]       dvsr,
    output logic                                      busy,
    output logic signed [pidaw_pkg::DATA_W-1:0]       quot
);

    localparam int NW = pidaw_pkg::DIV_NUM_W;
    localparam int DW = pidaw_pkg::DIFF_W;
    localparam int SW = pidaw_pkg::STEP_W;
    localparam int OW = pidaw_pkg::DATA_W;
    localparam logic [5:0] LAST_STEP = 6'(NW - 1);

    pidaw_pkg::div_state_t state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [DW-1:0]     diff_reg, diff_next;
    logic              neg_reg, neg_next;
    logic [NW-1:0]     quo_reg, quo_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [OW-1:0]     quot_reg, quot_next;

    logic [DW-1:0]     abs_diff;
    logic [SW:0]       shifted;
    logic [SW:0]       trial;
    logic              fits;
    logic              over_neg;

    assign abs_diff = diff_reg[DW-1] ? (DW'(0) - diff_reg) : diff_reg;
    assign shifted  = {rem_reg, quo_reg[NW-1]};
    assign trial    = shifted - {1'b0, dvsr};
    assign fits     = (shifted >= {1'b0, dvsr});
    // magnitude beyond the most negative data value
    assign over_neg = (|quo_reg[NW-1:OW]) || (quo_reg[OW-1] && |quo_reg[OW-2:0]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        diff_next  = diff_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        unique case (state_reg)
            pidaw_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    diff_next  = diff;
                    state_next = pidaw_pkg::DIV_ABS;
                end
            end
            pidaw_pkg::DIV_ABS:
            begin
                neg_next   = diff_reg[DW-1];
                quo_next   = {abs_diff, {pidaw_pkg::FRAC_W{1'b0}}};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = pidaw_pkg::DIV_RUN;
            end
            pidaw_pkg::DIV_RUN:
            begin
                rem_next = fits ? trial[SW-1:0] : shifted[SW-1:0];
                quo_next = {quo_reg[NW-2:0], fits};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP)
                    state_next = pidaw_pkg::DIV_FIN;
            end
            pidaw_pkg::DIV_FIN:
            begin
                if (!neg_reg)
                    quot_next = (|quo_reg[NW-1:OW-1]) ? pidaw_pkg::DATA_MAX
                                                      : quo_reg[OW-1:0];
                else
                    quot_next = over_neg ? pidaw_pkg::DATA_MIN
                                         : (OW'(0) - quo_reg[OW-1:0]);
                state_next = pidaw_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = pidaw_pkg::DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidaw_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy = (state_reg != pidaw_pkg::DIV_IDLE);
    assign quot = quot_reg;

endmodule

>>> sv/pid_antiwindup_filtered_derivative.sv
// pid controller top: integral clamp, filtered derivative, serial arithmetic
// one request at a time: a new error sample is taken only once the last drive value is registered
// the work is paced by the shared one-bit-per-cycle multiplier, four products or six
//   with the derivative filter on, issued one after another
// the 49-step derivative divider runs beside the first products and adds no time
// reset (rst_n low, asynchronous) clears integral, last error and last derivative,
//   gains and clamp to zero, step time to 1.0, filter off
module pid_antiwindup_filtered_derivative (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]       cfg_data,
    // error sample stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pidaw_pkg::DATA_W-1:0]           s_tdata,   // [31:0] error_in
    // drive value stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pidaw_pkg::DATA_W-1:0]           m_tdata    // [31:0] drive_out
);

    localparam int DW = pidaw_pkg::DATA_W;
    localparam int AW = pidaw_pkg::ACC_W;
    localparam int FW = pidaw_pkg::FRAC_W;
    localparam int WW = pidaw_pkg::WEIGHT_W;
    localparam int MW = pidaw_pkg::MUL_W;

    // configuration registers
    logic signed [DW-1:0]                 gain_p_reg;
    logic signed [DW-1:0]                 gain_i_reg;
    logic signed [DW-1:0]                 gain_d_reg;
    logic [pidaw_pkg::STEP_W-1:0]         step_time_reg;
    logic [pidaw_pkg::LIMIT_W-1:0]        integral_limit_reg;
    logic [WW-1:0]                        filter_weight_reg;

    // sequencer and datapath state
    pidaw_pkg::pid_state_t state_reg, state_next;
    logic signed [DW-1:0] e_reg, e_next;
    logic signed [DW-1:0] integral_reg, integral_next;
    logic signed [DW-1:0] last_error_reg, last_error_next;
    logic signed [DW-1:0] last_deriv_reg, last_deriv_next;
    logic signed [DW-1:0] deriv_reg, deriv_next;
    logic signed [AW-1:0] sum_reg, sum_next;
    logic signed [AW-1:0] work_reg, work_next;
    logic signed [DW-1:0] out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // arithmetic units
    pidaw_pkg::mul_req_t                     mul_req;
    logic                                    mul_done;
    logic signed [pidaw_pkg::PROD_W-1:0]     mul_prod;
    logic                                    div_start;
    logic signed [pidaw_pkg::DIFF_W-1:0]     div_diff;
    logic                                    div_busy;
    logic signed [DW-1:0]                    div_quot;

    // derived operands
    logic [pidaw_pkg::STEP_W-1:0]  dt_eff;
    logic [WW-1:0]                 w_eff;
    logic [WW-1:0]                 w_comp;
    logic signed [AW-1:0]          prod_term;
    logic signed [AW-1:0]          filt_sum;
    logic signed [DW-1:0]          int_sat;
    logic signed [DW-1:0]          int_clamped;
    logic signed [DW-1:0]          lim_pos;
    logic signed [DW-1:0]          lim_neg;

    // zero period counts as the smallest period
    assign dt_eff = (step_time_reg == '0) ? pidaw_pkg::STEP_W'(1) : step_time_reg;
    // weight above one counts as one
    assign w_eff  = (filter_weight_reg > pidaw_pkg::WEIGHT_ONE) ? pidaw_pkg::WEIGHT_ONE
                                                                : filter_weight_reg;
    assign w_comp = pidaw_pkg::WEIGHT_ONE - w_eff;

    // product shifted down by the fraction, floor rounding
    assign prod_term = mul_prod[pidaw_pkg::PROD_W-1:FW];
    assign filt_sum  = work_reg + mul_prod[AW-1:0];

    // integral: saturate first, then the symmetric clamp
    assign int_sat = pidaw_pkg::sat_acc(work_reg);
    assign lim_pos = {1'b0, integral_limit_reg};
    assign lim_neg = DW'(0) - lim_pos;

    always_comb
    begin
        int_clamped = int_sat;
        if (integral_limit_reg != '0)
        begin
            if (int_sat > lim_pos)
                int_clamped = lim_pos;
            else if (int_sat < lim_neg)
                int_clamped = lim_neg;
        end
    end

    // error difference for the derivative divide
    assign div_diff = {s_tdata[DW-1], s_tdata} - {last_error_reg[DW-1], last_error_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            step_time_reg      <= pidaw_pkg::STEP_RESET;
            integral_limit_reg <= '0;
            filter_weight_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidaw_pkg::REG_GAIN_P:         gain_p_reg <= cfg_data[DW-1:0];
                pidaw_pkg::REG_GAIN_I:         gain_i_reg <= cfg_data[DW-1:0];
                pidaw_pkg::REG_GAIN_D:         gain_d_reg <= cfg_data[DW-1:0];
                pidaw_pkg::REG_STEP_TIME:
                    step_time_reg <= cfg_data[pidaw_pkg::STEP_W-1:0];
                pidaw_pkg::REG_INTEGRAL_LIMIT:
                    integral_limit_reg <= cfg_data[pidaw_pkg::LIMIT_W-1:0];
                pidaw_pkg::REG_FILTER_WEIGHT:
                    filter_weight_reg <= cfg_data[WW-1:0];
                default:
                begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    // sequencer: walks the four products, six with the derivative filter on, one after another
    always_comb
    begin
        state_next      = state_reg;
        e_next          = e_reg;
        integral_next   = integral_reg;
        last_error_next = last_error_reg;
        last_deriv_next = last_deriv_reg;
        deriv_next      = deriv_reg;
        sum_next        = sum_reg;
        work_next       = work_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        mul_req         = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            pidaw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    e_next      = s_tdata;
                    div_start   = 1'b1;
                    mul_req.start = 1'b1;
                    mul_req.a   = pidaw_pkg::sext_mul(gain_p_reg);
                    mul_req.b   = pidaw_pkg::sext_mul(s_tdata);
                    state_next  = pidaw_pkg::ST_MUL_P;
                end
            end
            pidaw_pkg::ST_MUL_P:
            begin
                if (mul_done)
                begin
                    sum_next      = prod_term;
                    mul_req.start = 1'b1;
                    mul_req.a     = pidaw_pkg::sext_mul(e_reg);
                    mul_req.b     = {2'b00, dt_eff};
                    state_next    = pidaw_pkg::ST_MUL_INT;
                end
            end
            pidaw_pkg::ST_MUL_INT:
            begin
                if (mul_done)
                begin
                    work_next  = {{(AW-DW){integral_reg[DW-1]}}, integral_reg} + prod_term;
                    state_next = pidaw_pkg::ST_INT_SAT;
                end
            end
            pidaw_pkg::ST_INT_SAT:
            begin
                integral_next = int_clamped;
                state_next    = pidaw_pkg::ST_ISSUE_I;
            end
            pidaw_pkg::ST_ISSUE_I:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = pidaw_pkg::sext_mul(gain_i_reg);
                mul_req.b     = pidaw_pkg::sext_mul(integral_reg);
                state_next    = pidaw_pkg::ST_MUL_I;
            end
            pidaw_pkg::ST_MUL_I:
            begin
                if (mul_done)
                begin
                    sum_next   = sum_reg + prod_term;
                    state_next = pidaw_pkg::ST_WAIT_DIV;
                end
            end
            pidaw_pkg::ST_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    deriv_next = div_quot;
                    if (w_eff != '0)
                    begin
                        // old filtered derivative times one minus weight
                        mul_req.start = 1'b1;
                        mul_req.a     = pidaw_pkg::sext_mul(last_deriv_reg);
                        mul_req.b     = {{(MW-WW){1'b0}}, w_comp};
                        state_next    = pidaw_pkg::ST_MUL_F1;
                    end
                    else
                    begin
                        state_next = pidaw_pkg::ST_ISSUE_D;
                    end
                end
            end
            pidaw_pkg::ST_MUL_F1:
            begin
                if (mul_done)
                begin
                    work_next     = mul_prod[AW-1:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = pidaw_pkg::sext_mul(deriv_reg);
                    mul_req.b     = {{(MW-WW){1'b0}}, w_eff};
                    state_next    = pidaw_pkg::ST_MUL_F2;
                end
            end
            pidaw_pkg::ST_MUL_F2:
            begin
                if (mul_done)
                begin
                    // blend stays in range, floor shift by the weight fraction
                    deriv_next = filt_sum[pidaw_pkg::WEIGHT_FRAC+DW-1:pidaw_pkg::WEIGHT_FRAC];
                    state_next = pidaw_pkg::ST_ISSUE_D;
                end
            end
            pidaw_pkg::ST_ISSUE_D:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = pidaw_pkg::sext_mul(gain_d_reg);
                mul_req.b     = pidaw_pkg::sext_mul(deriv_reg);
                state_next    = pidaw_pkg::ST_MUL_D;
            end
            pidaw_pkg::ST_MUL_D:
            begin
                if (mul_done)
                begin
                    sum_next   = sum_reg + prod_term;
                    state_next = pidaw_pkg::ST_OUT;
                end
            end
            pidaw_pkg::ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    out_next        = pidaw_pkg::sat_acc(sum_reg);
                    out_valid_next  = 1'b1;
                    last_error_next = e_reg;
                    last_deriv_next = deriv_reg;
                    state_next      = pidaw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidaw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pidaw_pkg::ST_IDLE;
            integral_reg   <= '0;
            last_error_reg <= '0;
            last_deriv_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            integral_reg   <= integral_next;
            last_error_reg <= last_error_next;
            last_deriv_reg <= last_deriv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        deriv_reg <= deriv_next;
        sum_reg   <= sum_next;
        work_reg  <= work_next;
        out_reg   <= out_next;
    end

    pidaw_smul u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pidaw_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (div_diff),
        .dvsr  (dt_eff),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign s_tready = (state_reg == pidaw_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> tb/tb.sv
// testbench for the pid controller with integral clamp and filtered derivative
module tb;
    import pidaw_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 11;
    // settle margin, longer than the longest request-to-drive latency, which is with the filter on
    localparam int SETTLE_CYCLES = 250;
    // receiver hold-off that lets the block fill up and stall its input
    localparam int HOLD_CYCLES = 2500;
    // cycles without any accepted request or drive value before giving up
    localparam int QUIET_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    // indexes outside the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh0001_0000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;   // [31:0] error_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;        // [31:0] drive_out

    // controller registers as the block should hold them
    logic signed [DATA_W-1:0] kp_q = '0;
    logic signed [DATA_W-1:0] ki_q = '0;
    logic signed [DATA_W-1:0] kd_q = '0;
    logic [STEP_W-1:0]        period_q = STEP_RESET;
    logic [LIMIT_W-1:0]       clamp_q = '0;
    logic [WEIGHT_W-1:0]      weight_q = '0;

    // controller state: integral, previous error, previous (filtered) slope
    logic signed [DATA_W-1:0] integ_q = '0;
    logic signed [DATA_W-1:0] prev_err_q = '0;
    logic signed [DATA_W-1:0] prev_der_q = '0;

    // drive values still owed by the block, oldest first
    logic [DATA_W-1:0] pending_drive[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;
    bit hold_ask = 1'b0;

    pid_antiwindup_filtered_derivative uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // saturate to the signed data range
    function automatic logic signed [DATA_W-1:0] clip_data(input longint x);
        if (x > longint'(DATA_MAX))
            return DATA_MAX;
        if (x < longint'(DATA_MIN))
            return DATA_MIN;
        return x[DATA_W-1:0];
    endfunction

    // one controller tick: update the state and return the drive value
    function automatic logic [DATA_W-1:0] next_drive(input logic signed [DATA_W-1:0] e);
        longint ev;
        longint dt;
        longint wt;
        longint lim;
        longint acc;
        longint slope;
        longint total;
        ev  = longint'(e);
        dt  = longint'(period_q);
        wt  = longint'(weight_q);
        lim = longint'(clamp_q);
        // a zero period acts as the smallest one, weights above one act as one
        if (dt == 0)
            dt = 1;
        if (wt > longint'(WEIGHT_ONE))
            wt = longint'(WEIGHT_ONE);
        // integral: saturate first, then the symmetric clamp
        acc = longint'(clip_data(longint'(integ_q) + ((ev * dt) >>> FRAC_W)));
        if (lim != 0)
        begin
            if (acc > lim)
                acc = lim;
            if (acc < -lim)
                acc = -lim;
        end
        // slope: quotient truncated toward zero
        slope = longint'(clip_data(((ev - longint'(prev_err_q)) * (longint'(1) << FRAC_W))
                                   / dt));
        if (wt != 0)
            slope = (longint'(prev_der_q) * ((longint'(1) << WEIGHT_FRAC) - wt) + slope * wt)
                    >>> WEIGHT_FRAC;
        total = ((longint'(kp_q) * ev) >>> FRAC_W) + ((longint'(ki_q) * acc) >>> FRAC_W)
              + ((longint'(kd_q) * slope) >>> FRAC_W);
        integ_q    = acc[DATA_W-1:0];
        prev_err_q = e;
        prev_der_q = slope[DATA_W-1:0];
        return clip_data(total);
    endfunction

    // mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 6);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        logic [31:0] x;
        x = $urandom();
        case ($urandom_range(0, 9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3: return x;
            default: return {{13{x[18]}}, x[18:0]};   // within about +-4.0
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_period();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;                 // top bit falls outside the register
            3: return $urandom();
            default: return $urandom_range(1 << 12, 1 << 18);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_limit();
        case ($urandom_range(0, 7))
            0, 1: return '0;
            2: return 32'd1;
            3: return 32'h7FFF_FFFF;
            4: return $urandom();
            default: return $urandom_range(1 << 14, 1 << 22);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0, 1: return '0;
            2: return 32'(WEIGHT_ONE);
            3: return 32'd1;
            4: return $urandom_range(65537, 131071);
            5: return $urandom();
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    // offer one error sample and record the drive value it must produce
    task automatic send_error(input logic [DATA_W-1:0] e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        do @(posedge clk); while (!s_tready);
        pending_drive.push_back(next_drive(e));
    endtask

    // stop offering, wait for every drive value, then let the block settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_we stays high until the caller lowers it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAIN_P:         kp_q = val;
            REG_GAIN_I:         ki_q = val;
            REG_GAIN_D:         kd_q = val;
            REG_STEP_TIME:      period_q = val[STEP_W-1:0];
            REG_INTEGRAL_LIMIT: clamp_q = val[LIMIT_W-1:0];
            REG_FILTER_WEIGHT:  weight_q = val[WEIGHT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                             input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] dt,
                             input logic [CFG_DATA_W-1:0] lim,
                             input logic [CFG_DATA_W-1:0] w);
        quiesce();
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_STEP_TIME, dt);
        write_reg(REG_INTEGRAL_LIMIT, lim);
        write_reg(REG_FILTER_WEIGHT, w);
        cfg_we <= 1'b0;
    endtask

    // zero gains after reset: drive stays zero while the state moves
    task automatic test_reset_state();
        send_error(DATA_MAX);
        send_error(DATA_MIN);
        send_error('0);
    endtask

    // unit gains: integral, slope and output all run into saturation
    task automatic test_unit_gains();
        configure(ONE_Q, ONE_Q, ONE_Q, ONE_Q, '0, '0);
        send_error(DATA_MAX);
        send_error(DATA_MAX);
        send_error(DATA_MIN);
        send_error(32'hFFFF_FFFF);
        send_error(32'd1);
    endtask

    task automatic test_gain_extremes();
        configure(DATA_MIN, DATA_MAX, DATA_MIN, 32'd1, '0, '0);
        send_error(DATA_MIN);
        send_error(DATA_MAX);
        send_error('0);
    endtask

    // zero period must behave as the smallest period
    task automatic test_zero_period();
        configure(ONE_Q, ONE_Q, ONE_Q, '0, '0, '0);
        send_error(32'd3);
        send_error(-32'sd5);
        send_error(ONE_Q);
    endtask

    // weight above one, the smallest weight and a half blend
    task automatic test_filter_weight();
        configure('0, '0, ONE_Q, ONE_Q, '0, 32'h0001_FFFF);
        send_error(ONE_Q);
        send_error(-ONE_Q);
        configure('0, '0, ONE_Q, ONE_Q, '0, 32'd1);
        send_error(ONE_Q);
        configure('0, '0, ONE_Q, ONE_Q, '0, 32'd32768);
        send_error(-ONE_Q);
    endtask

    task automatic test_integral_clamp();
        configure('0, ONE_Q, '0, ONE_Q, 3 * ONE_Q, '0);
        send_error(2 * ONE_Q);
        send_error(2 * ONE_Q);
        send_error(-16 * ONE_Q);
        // widest clamp: the negative bound sits one above the saturated integral
        configure('0, ONE_Q, '0, ONE_Q, 32'h7FFF_FFFF, '0);
        send_error(DATA_MIN);
        send_error(DATA_MIN);
    endtask

    task automatic test_unknown_index();
        quiesce();
        write_reg(REG_UNUSED_6, $urandom());
        write_reg(REG_UNUSED_7, $urandom());
        cfg_we <= 1'b0;
        send_error($urandom());
        send_error($urandom());
    endtask

    // one random setting, then a mix of drifting errors, extremes and noise
    task automatic run_phase(input int items, input bit calm, input bit squeeze);
        logic signed [DATA_W-1:0] walk;
        logic [31:0]              x;
        configure(rand_gain(), rand_gain(), rand_gain(), rand_period(), rand_limit(),
                  rand_weight());
        idle_on = !calm;
        if (squeeze)
            hold_ask = 1'b1;
        walk = '0;
        repeat (items)
        begin
            x = $urandom();
            case ($urandom_range(0, 9))
                0: send_error(x[0] ? DATA_MAX : (x[1] ? DATA_MIN : '0));
                1: send_error(x);
                default:
                begin
                    // slowly drifting error, as from a loop settling
                    walk = walk + {{14{x[17]}}, x[17:0]};
                    send_error(walk);
                end
            endcase
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        repeat (6) run_phase(110, 1'b0, 1'b0);
    endtask

    task automatic test_back_to_back();
        run_phase(90, 1'b1, 1'b0);
    endtask

    task automatic test_output_backpressure();
        run_phase(80, 1'b0, 1'b1);
    endtask

    // receiver: random stalls, plus one long hold-off when a test asks for it
    initial
    begin : drive_ready
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && $urandom_range(0, 63) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // compare every accepted drive value against the oldest owed one
    always @(posedge clk)
    begin : check_drive
        logic [DATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drive.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("drive %h arrived with none owed", m_tdata);
            end
            else
            begin
                want = pending_drive.pop_front();
                if (m_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("drive_out mismatch: expected %h got %h", want, m_tdata);
                end
            end
        end
    end

    // watchdog on cycles where neither side moves a request or a drive value
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_unit_gains();
        test_gain_extremes();
        test_zero_period();
        test_filter_weight();
        test_integral_clamp();
        test_unknown_index();
        test_random_traffic();
        test_back_to_back();
        test_output_backpressure();

        quiesce();
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> pid_antiwindup_filtered_derivative.f
sv/pidaw_pkg.sv
sv/pidaw_smul.sv
sv/pidaw_sdiv.sv
sv/pid_antiwindup_filtered_derivative.sv
tb/tb.sv
